@@ rtl/nem_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the neighbourhood edge mask
// no dependencies

package nem_pkg;

   // default sizes handed to the top level parameters
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_PIXEL_BITS = 32;

   // fixed field widths
   localparam int OUT_BITS      = 32;
   localparam int IN_BITS       = 32;
   localparam int FWIDTH_BITS   = 11;
   localparam int FHEIGHT_BITS  = 12;
   localparam int ROW_BITS      = 11;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 12;

   // register reset values and limits
   localparam logic [FWIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd960;
   localparam logic [FHEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 12'd540;
   localparam logic [FHEIGHT_BITS-1:0] HEIGHT_LIMIT       = 12'd2048;
   localparam int                      MIN_DIM            = 3;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // per-item control carried from the input stage to the compute stage
   typedef struct packed {
      logic       with_center;  // item yields the pixel one row and one column back
      logic       full_window;  // that pixel is an interior pixel
      logic [1:0] res_count;    // results caused by this item, 0 to 2
      logic       frame_end;    // item closes the frame
   } item_flags_type;

   // one result beat
   typedef struct packed {
      logic [OUT_BITS-1:0] pixel;
      logic                run_last;
      logic                frame_last;
   } rsp_beat_type;

endpackage

@@ rtl/nem_line_mem.sv @@
`timescale 1ns / 1ps
// one line store: single write port, single read port, registered read data
// depends on nothing

module nem_line_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/nem_window.sv @@
`timescale 1ns / 1ps
// 3x3 window: two stored columns plus the incoming column, uniformity check
// depends on nothing

module nem_window #(
   parameter int PIXEL_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic [PIXEL_BITS-1:0] top_pix,
   input  logic [PIXEL_BITS-1:0] mid_pix,
   input  logic [PIXEL_BITS-1:0] new_pix,
   output logic [PIXEL_BITS-1:0] edge_pix
);

   // columns: 0..2 oldest (top, mid, bottom), 3..5 newer
   logic [PIXEL_BITS-1:0] win_ff [6];
   logic [PIXEL_BITS-1:0] win_in [6];
   logic [PIXEL_BITS-1:0] center;
   logic                  uniform;

   // shift one column in
   always_comb begin
      win_in[0] = win_ff[3];
      win_in[1] = win_ff[4];
      win_in[2] = win_ff[5];
      win_in[3] = top_pix;
      win_in[4] = mid_pix;
      win_in[5] = new_pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // all nine words equal to the center
   always_comb begin
      center  = win_ff[4];
      uniform = (top_pix == center) && (mid_pix == center) && (new_pix == center);
      for (int i = 0; i < 6; i++) begin
         if (win_ff[i] != center) begin
            uniform = 1'b0;
         end
      end
   end

   assign edge_pix = uniform ? '0 : center;

endmodule

@@ rtl/nem_rsp_fifo.sv @@
`timescale 1ns / 1ps
// two-entry result queue between the compute stage and the rsp channel
// depends on nem_pkg

module nem_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nem_pkg::rsp_beat_type push_beat,
   output logic                  can_push,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // pixel_out
   output logic                  rsp_tuser,  // run_last
   output logic                  rsp_tlast   // frame_last
);

   nem_pkg::rsp_beat_type entry_ff [2];
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            count_ff;
   logic [1:0]            count_in;
   logic                  pop;
   logic                  do_push;

   // push decision uses only stored state, so can_push has no combinational path from rsp_tready
   assign can_push = (count_ff != 2'd2);
   assign do_push  = push && can_push;
   assign pop      = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = entry_ff[rd_ptr_ff].pixel;
   assign rsp_tuser  = entry_ff[rd_ptr_ff].run_last;
   assign rsp_tlast  = entry_ff[rd_ptr_ff].frame_last;

endmodule

@@ rtl/neighbourhood_edge_mask.sv @@
`timescale 1ns / 1ps
// top level of the 3x3 neighbourhood edge mask
// depends on nem_pkg, nem_line_mem, nem_window, nem_rsp_fifo

// Takes one 32-bit pixel per clock in raster order unless stalled and returns,
// per frame, frame_width * frame_height beats: a pixel passes where its 3x3
// neighbourhood holds at least two different words, and is zero elsewhere and
// on the border. Results run one row and one pixel behind the input. Each pixel
// is looked up in two line stores (registered read) and enters the compute
// stage the cycle after it is accepted; the column is written back as it
// leaves, so the store port pair sets the rate of one pixel per cycle unless
// the compute stage is held. An input that causes two results (row ends after
// the first row and every pixel of the last row) holds the compute stage until
// both are queued, since one beat is queued per cycle while the queue has room.
// The line stores need no clearing pass; frame_width and frame_height must be
// written over the csr port only while the block is idle, which the block does
// not enforce, and are clamped to 3..MAX_WIDTH and 3..2048.

module neighbourhood_edge_mask #(
   parameter int MAX_WIDTH  = nem_pkg::DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = nem_pkg::DEF_PIXEL_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // input pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pixel_in
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_out
   output logic        rsp_tuser,   // run_last
   output logic        rsp_tlast,   // frame_last
   // configuration writes
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [11:0] csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WSAT_W = $clog2(MAX_WIDTH + 1);
   localparam int WCMP_W = (WSAT_W > nem_pkg::FWIDTH_BITS) ? WSAT_W : nem_pkg::FWIDTH_BITS;
   localparam int ROW_W  = nem_pkg::ROW_BITS;

   // configuration registers
   logic [nem_pkg::FWIDTH_BITS-1:0]  width_ff;
   logic [nem_pkg::FHEIGHT_BITS-1:0] height_ff;

   // position of the next input pixel
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;

   // compute stage
   logic                    s1_valid_ff;
   logic                    s1_sel_ff;
   logic [PIXEL_BITS-1:0]   s1_pix_ff;
   logic [COL_W-1:0]        s1_idx_ff;
   nem_pkg::item_flags_type s1_flags_ff;

   logic                    accept;
   logic [WCMP_W-1:0]       width_wide;
   logic [WSAT_W-1:0]       w_sat;
   logic [WSAT_W-1:0]       w_last;
   logic [nem_pkg::FHEIGHT_BITS-1:0] h_sat;
   logic [nem_pkg::FHEIGHT_BITS-1:0] h_last;
   logic                    row_end;
   logic                    last_row;
   logic [COL_W-1:0]        rd_idx;
   logic [PIXEL_BITS+31:0]  pix_wide;
   logic [PIXEL_BITS-1:0]   pix_in;
   nem_pkg::item_flags_type flags_in;
   logic                    mid_row_tail;

   logic [PIXEL_BITS-1:0]   top_rd;
   logic [PIXEL_BITS-1:0]   mid_rd;
   logic [PIXEL_BITS-1:0]   edge_pix;
   logic [PIXEL_BITS-1:0]   first_pix;
   logic [PIXEL_BITS+31:0]  out_wide;
   logic                    last_sel;
   logic                    can_push;
   logic                    push;
   logic                    s1_done;
   nem_pkg::rsp_beat_type   push_beat;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nem_pkg::FRAME_WIDTH_RESET;
         height_ff <= nem_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            nem_pkg::CSR_FRAME_WIDTH: begin
               width_ff <= csr_wdata[nem_pkg::FWIDTH_BITS-1:0];
            end
            nem_pkg::CSR_FRAME_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // clamp frame size
   always_comb begin
      width_wide = WCMP_W'(width_ff);
      if (width_wide < WCMP_W'(nem_pkg::MIN_DIM)) begin
         w_sat = WSAT_W'(nem_pkg::MIN_DIM);
      end else if (width_wide > WCMP_W'(MAX_WIDTH)) begin
         w_sat = WSAT_W'(MAX_WIDTH);
      end else begin
         w_sat = width_wide[WSAT_W-1:0];
      end
      w_last = w_sat - WSAT_W'(1);

      if (height_ff < nem_pkg::FHEIGHT_BITS'(nem_pkg::MIN_DIM)) begin
         h_sat = nem_pkg::FHEIGHT_BITS'(nem_pkg::MIN_DIM);
      end else if (height_ff > nem_pkg::HEIGHT_LIMIT) begin
         h_sat = nem_pkg::HEIGHT_LIMIT;
      end else begin
         h_sat = height_ff;
      end
      h_last = h_sat - nem_pkg::FHEIGHT_BITS'(1);
   end

   // input stage: position decode and store address
   always_comb begin
      row_end      = (WSAT_W'(col_ff) >= w_last);
      last_row     = (row_ff >= h_last[ROW_W-1:0]);
      rd_idx       = row_end ? w_last[COL_W-1:0] : col_ff;
      mid_row_tail = last_row && !row_end;

      flags_in.with_center = (row_ff != '0) && (col_ff != '0);
      flags_in.full_window = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      flags_in.res_count   = 2'(flags_in.with_center)
                           + 2'(row_end && (row_ff != '0))
                           + 2'(mid_row_tail)
                           + 2'(mid_row_tail && (col_ff == '0));
      flags_in.frame_end   = row_end && last_row;

      pix_wide = {{PIXEL_BITS{1'b0}}, req_tdata};
      pix_in   = pix_wide[PIXEL_BITS-1:0];
   end

   assign accept = req_tvalid && req_tready;

   // position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // line stores: read at accept, write back when the item leaves the compute stage;
   // neighbouring items never share a column, so no forwarding is needed
   nem_line_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIXEL_BITS)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (s1_done),
      .wr_addr (s1_idx_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (top_rd)
   );

   nem_line_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIXEL_BITS)
   ) u_line_middle (
      .clock   (clock),
      .wr_en   (s1_done),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (mid_rd)
   );

   // compute stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_sel_ff   <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_done) begin
            s1_sel_ff <= 1'b0;
         end else if (push) begin
            s1_sel_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= pix_in;
         s1_idx_ff   <= rd_idx;
         s1_flags_ff <= flags_in;
      end
   end

   nem_window #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_done),
      .top_pix  (top_rd),
      .mid_pix  (mid_rd),
      .new_pix  (s1_pix_ff),
      .edge_pix (edge_pix)
   );

   // result sequencing: one beat per cycle while the queue has room, first beat may carry a pixel
   always_comb begin
      last_sel = (s1_flags_ff.res_count == 2'd2);
      push     = s1_valid_ff && (s1_flags_ff.res_count != 2'd0) && can_push;
      s1_done  = s1_valid_ff
               && ((s1_flags_ff.res_count == 2'd0) || (can_push && (s1_sel_ff == last_sel)));

      first_pix = (s1_flags_ff.with_center && s1_flags_ff.full_window) ? edge_pix : '0;
      out_wide  = {32'b0, (s1_sel_ff ? {PIXEL_BITS{1'b0}} : first_pix)};

      push_beat.pixel      = out_wide[nem_pkg::OUT_BITS-1:0];
      push_beat.run_last   = (s1_sel_ff == last_sel);
      push_beat.frame_last = (s1_sel_ff == last_sel) && s1_flags_ff.frame_end;
   end

   assign req_tready = !s1_valid_ff || s1_done;

   nem_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_beat  (push_beat),
      .can_push   (can_push),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ bench/neighbourhood_edge_mask_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the 3x3 neighbourhood edge mask: frames in, masked pixels out
// depends on nem_pkg and neighbourhood_edge_mask; a local predictor checks every rsp beat

module neighbourhood_edge_mask_tb;

   localparam int          CLK_HALF     = 6;
   localparam int          RESET_CYCLES = 12;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          IDLE_GAP     = 8;
   localparam int          TAIL_CYCLES  = 20;
   localparam int          HOLD_CYCLES  = 500;
   localparam int          RANDOM_ITEMS = 550;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
   localparam logic [31:0] TONE_A       = 32'h5A5A_5A5A;
   localparam logic [31:0] TONE_B       = 32'hA5A5_A5A5;

   typedef enum int {
      STYLE_NOISE,
      STYLE_BLOCKS,
      STYLE_SPECKLE,
      STYLE_PAIR
   } frame_style_type;

   // one directed input beat; when typed, every result it causes must carry result_pix
   typedef struct packed {
      logic [31:0] pix;
      logic        typed;
      logic [31:0] result_pix;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [0:0]  csr_addr;
   logic [11:0] csr_wdata;

   // side info travelling with the offered beat
   logic        req_typed;
   logic [31:0] req_typed_pix;

   int tx_idle_pct;
   int rx_stall_pct;
   int hold_requests;
   int cycle_count = 0;
   int mismatch_count;

   // predictor state
   logic [nem_pkg::FWIDTH_BITS-1:0]  cfg_width  = nem_pkg::FRAME_WIDTH_RESET;
   logic [nem_pkg::FHEIGHT_BITS-1:0] cfg_height = nem_pkg::FRAME_HEIGHT_RESET;
   logic [31:0]             line_above  [0:nem_pkg::DEF_MAX_WIDTH-1];
   logic [31:0]             line_middle [0:nem_pkg::DEF_MAX_WIDTH-1];
   logic [31:0]             window_pix  [0:5];
   int unsigned             col_pos;
   int unsigned             row_pos;
   nem_pkg::rsp_beat_type   pending_mask_beats [$];

   // three 3x3 frames: flat field, one odd corner, a distinct centre
   directed_row_type directed_rows [0:26] = '{
      // flat all-ones frame, every result zero
      '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0},
      '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0},
      '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0},
      // zero corner makes the centre pass on the last beat
      '{32'h0,    1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0},
      '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0},
      '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b1, 32'h0}, '{ALL_ONES, 1'b0, 32'h0},
      // centre differs from its ring
      '{TONE_A,   1'b1, 32'h0}, '{TONE_A,   1'b1, 32'h0}, '{TONE_A,   1'b1, 32'h0},
      '{TONE_A,   1'b1, 32'h0}, '{TONE_B,   1'b1, 32'h0}, '{TONE_A,   1'b1, 32'h0},
      '{TONE_A,   1'b1, 32'h0}, '{TONE_A,   1'b1, 32'h0}, '{TONE_A,   1'b0, 32'h0}
   };

   neighbourhood_edge_mask dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int unsigned clamped_width();
      int unsigned w;
      w = cfg_width;
      if (w < nem_pkg::MIN_DIM) w = nem_pkg::MIN_DIM;
      if (w > nem_pkg::DEF_MAX_WIDTH) w = nem_pkg::DEF_MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned clamped_height();
      int unsigned h;
      h = cfg_height;
      if (h < nem_pkg::MIN_DIM) h = nem_pkg::MIN_DIM;
      if (h > nem_pkg::HEIGHT_LIMIT) h = nem_pkg::HEIGHT_LIMIT;
      return h;
   endfunction

   function automatic logic [31:0] pick_colour();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return 32'h0;
      if (roll < 40) return ALL_ONES;
      return $urandom;
   endfunction

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endfunction

   // expected beats for one accepted pixel, then advance the line stores and window
   task automatic predict_edge_mask(input logic [31:0] pix, input logic typed,
                                    input logic [31:0] typed_pix);
      int unsigned  w;
      int unsigned  h;
      int unsigned  idx;
      int           n;
      int           k;
      logic [31:0]  above_pix;
      logic [31:0]  middle_pix;
      logic [31:0]  centre_pix;
      logic         row_end;
      logic         last_row;
      logic         differs;
      nem_pkg::rsp_beat_type beats [0:2];
      w = clamped_width();
      h = clamped_height();
      n = 0;
      row_end  = (col_pos >= w - 1);
      last_row = (row_pos >= h - 1);
      idx = row_end ? w - 1 : col_pos;
      above_pix  = line_above[idx];
      middle_pix = line_middle[idx];

      // pixel one row and one column back; only interior pixels can pass
      if (row_pos >= 1 && col_pos >= 1) begin
         centre_pix = window_pix[4];
         differs = 1'b0;
         for (k = 0; k < 6; k++)
            if (window_pix[k] != centre_pix) differs = 1'b1;
         if (above_pix != centre_pix || middle_pix != centre_pix || pix != centre_pix)
            differs = 1'b1;
         beats[n] = '{(row_pos >= 2 && col_pos >= 2 && differs) ? centre_pix : 32'h0,
                      1'b0, 1'b0};
         n++;
      end
      // right border of the row above
      if (row_end && row_pos >= 1) begin
         beats[n] = '0;
         n++;
      end
      // bottom border zeros interleaved, two on the first column
      if (last_row && !row_end) begin
         beats[n] = '0;
         n++;
         if (col_pos == 0) begin
            beats[n] = '0;
            n++;
         end
      end
      if (n > 0) begin
         beats[n-1].run_last = 1'b1;
         if (row_end && last_row) beats[n-1].frame_last = 1'b1;
      end
      for (k = 0; k < n; k++) begin
         if (typed) beats[k].pixel = typed_pix;
         pending_mask_beats.push_back(beats[k]);
      end

      window_pix[0] = window_pix[3];
      window_pix[1] = window_pix[4];
      window_pix[2] = window_pix[5];
      window_pix[3] = above_pix;
      window_pix[4] = middle_pix;
      window_pix[5] = pix;
      line_above[idx]  = middle_pix;
      line_middle[idx] = pix;
      if (row_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   // accepted req beats feed the predictor, accepted rsp beats are checked
   always @(posedge clock) begin : watch_beats
      nem_pkg::rsp_beat_type exp_beat;
      if (reset === 1'b0) begin
         if (req_tvalid && req_tready)
            predict_edge_mask(req_tdata, req_typed, req_typed_pix);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_mask_beats.size() == 0) begin
               note_failure($sformatf("unexpected beat pixel=%h run_last=%b frame_last=%b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               exp_beat = pending_mask_beats.pop_front();
               if (rsp_tdata !== exp_beat.pixel || rsp_tuser !== exp_beat.run_last ||
                   rsp_tlast !== exp_beat.frame_last)
                  note_failure($sformatf(
                     "pixel exp %h act %h, run_last exp %b act %b, frame_last exp %b act %b",
                     exp_beat.pixel, rsp_tdata, exp_beat.run_last, rsp_tuser,
                     exp_beat.frame_last, rsp_tlast));
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold whenever one is requested
   initial begin : rsp_side
      int holds_done;
      holds_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
         end
      end
   end

   // offer one pixel, entered and left at a falling edge
   task automatic send_beat(input logic [31:0] pix, input logic typed,
                            input logic [31:0] typed_pix);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= pix;
      req_typed     <= typed;
      req_typed_pix <= typed_pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // rows of the current width with content of the given style, a whole frame
   // when rows is the frame height
   task automatic send_rows(input frame_style_type style, input int unsigned rows);
      int unsigned w;
      int unsigned h;
      int unsigned split_x;
      int unsigned split_y;
      logic [31:0] colour_a;
      logic [31:0] colour_b;
      logic [31:0] pix;
      w = clamped_width();
      h = clamped_height();
      colour_a = pick_colour();
      colour_b = pick_colour();
      split_x = $urandom_range(0, w);
      split_y = $urandom_range(0, h);
      for (int unsigned y = 0; y < rows; y++) begin
         for (int unsigned x = 0; x < w; x++) begin
            case (style)
               STYLE_NOISE: begin
                  pix = $urandom;
               end
               STYLE_BLOCKS: begin
                  pix = ((x >= split_x) ^ (y >= split_y)) ? colour_b : colour_a;
               end
               STYLE_SPECKLE: begin
                  pix = ($urandom_range(0, 15) == 0) ? $urandom : colour_a;
               end
               default: begin
                  pix = $urandom_range(0, 1) ? colour_b : colour_a;
               end
            endcase
            send_beat(pix, 1'b0, 32'h0);
         end
      end
   endtask

   // wait for the block to drain, then write both size registers
   task automatic start_phase(input logic [11:0] width_raw, input logic [11:0] height_raw,
                              input int mode);
      req_tvalid <= 1'b0;
      while (pending_mask_beats.size() != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= nem_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= width_raw;
      @(negedge clock);
      csr_addr  <= nem_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= height_raw;
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_width  = width_raw[nem_pkg::FWIDTH_BITS-1:0];
      cfg_height = height_raw;
      tx_idle_pct  = (mode == 1) ? 59 : (mode == 3) ? 16 : 0;
      rx_stall_pct = (mode == 2) ? 59 : (mode == 3) ? 16 : 0;
   endtask

   function automatic frame_style_type pick_style();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return STYLE_NOISE;
      if (roll < 50) return STYLE_BLOCKS;
      if (roll < 85) return STYLE_SPECKLE;
      return STYLE_PAIR;
   endfunction

   // main sequence
   initial begin : main_flow
      int          random_items;
      int          phase;
      int          frames;
      logic [11:0] width_raw;
      logic [11:0] height_raw;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_typed     = 1'b0;
      req_typed_pix = '0;
      csr_we        = 1'b0;
      csr_addr      = nem_pkg::CSR_FRAME_WIDTH;
      csr_wdata     = '0;
      tx_idle_pct   = 0;
      rx_stall_pct  = 0;
      hold_requests = 0;
      mismatch_count = 0;
      col_pos = 0;
      row_pos = 0;
      for (int k = 0; k < 6; k++) window_pix[k] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: sizes below the minimum clamp to 3x3
      start_phase(12'd2, 12'd0, 0);
      foreach (directed_rows[i])
         send_beat(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].result_pix);

      // one widest row, width clamped from an oversized write, frame closed at 3x3
      start_phase(12'hFFF, 12'd3, 3);
      send_rows(pick_style(), 1);
      start_phase(12'd3, 12'd3, 3);
      send_rows(pick_style(), 2);

      // height clamped from an oversized write, frame cut short by a smaller height
      start_phase(12'd3, 12'hFFF, 0);
      send_rows(STYLE_BLOCKS, 4);
      start_phase(12'd3, 12'd3, 0);
      send_rows(STYLE_BLOCKS, 1);

      // long receiver hold while pixels keep coming
      start_phase(12'd20, 12'd12, 0);
      hold_requests++;
      send_rows(pick_style(), clamped_height());

      // random small frames across the idling modes
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         width_raw  = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
                                                  : 12'($urandom_range(3, 16));
         height_raw = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
                                                  : 12'($urandom_range(3, 12));
         start_phase(width_raw, height_raw, phase % 4);
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            send_rows(pick_style(), clamped_height());
            random_items += clamped_width() * clamped_height();
         end
         phase++;
      end
      req_tvalid <= 1'b0;

      // drain and a short tail for stray beats
      while (pending_mask_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_mask_beats.size() != 0)
         note_failure($sformatf("%0d beats never arrived", pending_mask_beats.size()));
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
